FILE: sv/tks_pkg.sv
// ----------------------------------------------------------------------------
// tks_pkg
// Shared types and constants of the top-k score table: command codes, the
// request and response words, one table entry and the link between cells.
// ----------------------------------------------------------------------------
`default_nettype none

package tks_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2
   } cmd_type;

   typedef struct packed {
      logic [1:0]         command;
      logic signed [31:0] score;
      logic [1:0]         player;
      logic [31:0]        name_tag;
      logic [3:0]         rank;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic               entry_valid;
      logic signed [31:0] entry_score;
      logic [1:0]         entry_player;
      logic [31:0]        entry_name_tag;
      logic [4:0]         entry_count;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] score;
      logic [1:0]         player;
      logic [31:0]        name_tag;
   } entry_type;

   // what one cell tells the next one down the row
   typedef struct packed {
      logic occ;
      logic hit;
   } link_type;

endpackage

`default_nettype wire

FILE: sv/tks_cell.sv
// ----------------------------------------------------------------------------
// tks_cell
// One slot of the sorted table. Compares its score with the new entry and,
// from its upper neighbor's link, either loads the new entry, takes the
// neighbor's entry (shift down) or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_cell (
   input  logic                clock,
   input  logic                insert_en,
   input  logic                occ,
   input  tks_pkg::entry_type  new_entry,
   input  tks_pkg::entry_type  prev_entry,
   input  tks_pkg::link_type   prev_link,
   output tks_pkg::entry_type  entry,
   output tks_pkg::link_type   link
);
   import tks_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      hit;
   logic      load_new;
   logic      shift;

   assign hit = occ && (entry_ff.score < new_entry.score);

   // first slot below the new score, or the first free slot when none is
   assign load_new = insert_en && !prev_link.hit && (hit || (!occ && prev_link.occ));
   assign shift    = insert_en && prev_link.hit;

   always_comb begin
      entry_in = entry_ff;
      if (shift) begin
         entry_in = prev_entry;
      end else if (load_new) begin
         entry_in = new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry    = entry_ff;
   assign link.occ = occ;
   assign link.hit = hit;

endmodule

`default_nettype wire

FILE: sv/tks_rsp_buffer.sv
// ----------------------------------------------------------------------------
// tks_rsp_buffer
// Two-word response buffer: an output register and a skid register, so the
// request side stalls only when both hold a word.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_rsp_buffer (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  tks_pkg::rsp_type  in_word,
   output logic              in_stall,
   output logic              out_valid,
   input  logic              out_stall,
   output tks_pkg::rsp_type  out_word
);
   import tks_pkg::*;

   logic    out_valid_ff;
   logic    out_valid_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type out_word_ff;
   rsp_type out_word_in;
   rsp_type skid_word_ff;
   rsp_type skid_word_in;
   logic    push;
   logic    pop;

   assign push = in_valid && !skid_valid_ff;
   assign pop  = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_word_in   = out_word_ff;
      skid_word_in  = skid_word_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            out_word_in   = skid_word_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_word_in  = in_word;
            out_valid_in = push;
         end
      end else if (push) begin
         skid_word_in  = in_word;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_word_ff  <= out_word_in;
      skid_word_ff <= skid_word_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

endmodule

`default_nettype wire

FILE: sv/top_k_score_table_core.sv
// ----------------------------------------------------------------------------
// top_k_score_table_core
// Sorted top-k score table built as a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// The block accepts one command word (insert, read at rank, clear) per clock
// while req_stall is low: each cell compares its own score with the new one
// in parallel and loads, shifts or holds at the same edge. A read selects the
// cell at the rank and returns it with the count held after the word. Results
// pass through a two-word buffer; req_stall rises only when both buffer words
// are waiting.
`default_nettype none

module top_k_score_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tks_pkg::req_type  req_word,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tks_pkg::rsp_type  rsp_word
);
   import tks_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               accept;
   logic               full;
   logic               insert_en;
   logic               tag_ok;
   entry_type          new_entry;
   entry_type          rd_entry;
   entry_type          cell_entry [TABLE_DEPTH];
   link_type           cell_link  [TABLE_DEPTH];
   logic               cell_occ   [TABLE_DEPTH];
   rsp_type            rsp_in;

   localparam link_type LINK_HEAD = '{occ: 1'b1, hit: 1'b0};

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign tag_ok = (req_word.name_tag != 32'd0);

   assign new_entry.score    = req_word.score;
   assign new_entry.player   = req_word.player;
   assign new_entry.name_tag = req_word.name_tag;

   // full table takes the word only if it beats the bottom slot
   assign insert_en = accept && (req_word.command == CMD_INSERT) && tag_ok
                      && (!full || cell_link[TABLE_DEPTH-1].hit);

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign cell_occ[i] = (int'(count_ff) > i);
      if (i == 0) begin : g_head
         tks_cell u_cell (
            .clock      (clock),
            .insert_en  (insert_en),
            .occ        (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry (new_entry),
            .prev_link  (LINK_HEAD),
            .entry      (cell_entry[i]),
            .link       (cell_link[i])
         );
      end else begin : g_body
         tks_cell u_cell (
            .clock      (clock),
            .insert_en  (insert_en),
            .occ        (cell_occ[i]),
            .new_entry  (new_entry),
            .prev_entry (cell_entry[i-1]),
            .prev_link  (cell_link[i-1]),
            .entry      (cell_entry[i]),
            .link       (cell_link[i])
         );
      end
   end

   always_comb begin
      rd_entry = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (int'(req_word.rank) == i) begin
            rd_entry = cell_entry[i];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      rsp_in   = '0;
      if (accept) begin
         case (req_word.command)
            CMD_INSERT: begin
               rsp_in.accepted = insert_en;
               if (insert_en && !full) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            CMD_READ: begin
               if (int'(req_word.rank) < int'(count_ff)) begin
                  rsp_in.entry_valid    = 1'b1;
                  rsp_in.entry_score    = rd_entry.score;
                  rsp_in.entry_player   = rd_entry.player;
                  rsp_in.entry_name_tag = rd_entry.name_tag;
               end
            end
            CMD_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end
      rsp_in.entry_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   tks_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_word   (rsp_in),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

endmodule

`default_nettype wire

FILE: sv/tks_checker.sv
// ----------------------------------------------------------------------------
// tks_checker
// Port-level checks of the top-k score table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tks_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input tks_pkg::req_type  req_word,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tks_pkg::rsp_type  rsp_word
);
   import tks_pkg::*;

   // request side only stalls while results are waiting
   a_stall_needs_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall without a pending word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_word)))
      else $error("stalled response word changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response word right after reset");

   // an insert result never carries read data
   a_accept_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.accepted) |-> (!rsp_word.entry_valid
         && rsp_word.entry_count != 5'd0))
      else $error("accepted insert with read data or empty table");

   a_read_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.entry_valid) |-> (rsp_word.entry_count != 5'd0))
      else $error("valid read from an empty table");

endmodule

bind top_k_score_table_core tks_checker u_tks_checker (.*);

`default_nettype wire

FILE: bench/score_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// score_table_checker
// Watches both channels of the top-k score table, keeps its own sorted copy
// of the table, works out the reply for every accepted request word and
// compares each accepted reply word, field by field, with the oldest one due.
// ----------------------------------------------------------------------------

module score_table_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  tks_pkg::req_type req_word,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  tks_pkg::rsp_type rsp_word,
   output int               mismatches,
   output int               replies_left
);
   import tks_pkg::*;

   logic signed [31:0] held_score  [TABLE_DEPTH];
   logic [1:0]         held_player [TABLE_DEPTH];
   logic [31:0]        held_tag    [TABLE_DEPTH];
   int                 held_n;

   rsp_type replies_due[$];
   rsp_type want;

   // updates the table copy with one word and returns the reply it causes
   function automatic rsp_type apply_table_word(input req_type w);
      rsp_type r;
      int      slot;
      bit      found;
      r     = '0;
      slot  = 0;
      found = 0;
      case (w.command)
         CMD_INSERT: begin
            if (w.name_tag != 32'd0 &&
                !(held_n >= TABLE_DEPTH &&
                  $signed(w.score) <= $signed(held_score[TABLE_DEPTH-1]))) begin
               slot = held_n;
               // new entry lands after every equal or higher score
               for (int i = 0; i < held_n; i++) begin
                  if (!found && $signed(held_score[i]) < $signed(w.score)) begin
                     slot  = i;
                     found = 1;
                  end
               end
               if (held_n < TABLE_DEPTH)
                  held_n++;
               for (int i = held_n - 1; i > slot; i--) begin
                  held_score[i]  = held_score[i-1];
                  held_player[i] = held_player[i-1];
                  held_tag[i]    = held_tag[i-1];
               end
               held_score[slot]  = w.score;
               held_player[slot] = w.player;
               held_tag[slot]    = w.name_tag;
               r.accepted = 1'b1;
            end
         end
         CMD_READ: begin
            if (int'(w.rank) < held_n) begin
               r.entry_valid    = 1'b1;
               r.entry_score    = held_score[w.rank];
               r.entry_player   = held_player[w.rank];
               r.entry_name_tag = held_tag[w.rank];
            end
         end
         CMD_CLEAR: held_n = 0;
         default: ;
      endcase
      r.entry_count = held_n[4:0];
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
      if (exp_v !== got_v) begin
         $display("%0t: %s expected %h, got %h", $time, label, exp_v, got_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         held_n     = 0;
         mismatches = 0;
         replies_due.delete();
      end else begin
         if (req_valid && !req_stall)
            replies_due.push_back(apply_table_word(req_word));
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t: reply word expected none, got %h", $time, rsp_word);
               mismatches++;
            end else begin
               want = replies_due.pop_front();
               check_field("accepted", want.accepted, rsp_word.accepted);
               check_field("entry_valid", want.entry_valid, rsp_word.entry_valid);
               check_field("entry_score", want.entry_score, rsp_word.entry_score);
               check_field("entry_player", want.entry_player, rsp_word.entry_player);
               check_field("entry_name_tag", want.entry_name_tag,
                           rsp_word.entry_name_tag);
               check_field("entry_count", want.entry_count, rsp_word.entry_count);
            end
         end
      end
      replies_left = replies_due.size();
   end

endmodule

FILE: bench/top_k_score_table_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// top_k_score_table_core_test
// Drives the top-k score table with a directed opening (empty reads, empty
// names, extreme and equal scores, a full table, clear), then a long run of
// random words, mostly inserts and reads, under bursts and stall patterns.
// ----------------------------------------------------------------------------

module top_k_score_table_core_test;
   import tks_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         RANDOM_WORDS = 700;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   int         mismatches;
   int         replies_left;
   int         burst_left;
   logic [8:0] stall_cycle;

   top_k_score_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   score_table_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_word     (req_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_word     (rsp_word),
      .mismatches   (mismatches),
      .replies_left (replies_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // receiver: stall mode steps through four modes chosen by stall_cycle[8:7]
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         stall_cycle <= '0;
      end else begin
         stall_cycle <= stall_cycle + 9'd1;
         case (stall_cycle[8:7])
            2'd0: rsp_stall <= 1'b0;
            2'd1: rsp_stall <= ($urandom_range(0, 9) < 3);
            2'd2: rsp_stall <= ($urandom_range(0, 9) < 8);
            default: rsp_stall <= (stall_cycle[2:0] >= 3'd5);
         endcase
      end
   end

   function automatic req_type make_word(input logic [1:0] cmd, input logic [31:0] score,
                                         input logic [1:0] player, input logic [31:0] tag,
                                         input logic [3:0] rank);
      req_type w;
      w.command  = cmd;
      w.score    = score;
      w.player   = player;
      w.name_tag = tag;
      w.rank     = rank;
      return w;
   endfunction

   function automatic logic [31:0] pick_score();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         end
         1, 2: return $urandom;
         // narrow range so equal scores are common
         default: return int'($urandom_range(0, 40)) - 20;
      endcase
   endfunction

   // holds the word until it is taken, then continues the burst or idles
   task automatic send_word(input req_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end else begin
         burst_left--;
      end
   endtask

   initial begin
      logic [1:0]  cmd;
      logic [31:0] tag;
      int          pick;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_word   = '0;
      burst_left = 4;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty table, empty name, extreme and equal scores, unused code
      send_word(make_word(CMD_READ, 32'h0, 2'd0, 32'h0, 4'd0));
      send_word(make_word(CMD_INSERT, 32'd5, 2'd1, 32'h0, 4'd0));
      send_word(make_word(CMD_INSERT, 32'h7fff_ffff, 2'd3, 32'hffff_ffff, 4'd15));
      send_word(make_word(CMD_INSERT, 32'h8000_0000, 2'd0, 32'h1, 4'd0));
      send_word(make_word(CMD_INSERT, 32'h0, 2'd1, 32'h2, 4'd0));
      send_word(make_word(CMD_INSERT, 32'h0, 2'd2, 32'h3, 4'd0));
      send_word(make_word(CMD_INSERT, 32'hffff_ffff, 2'd3, 32'h8000_0000, 4'd0));
      send_word(make_word(CMD_UNUSED, 32'hffff_ffff, 2'd3, 32'hffff_ffff, 4'd15));
      send_word(make_word(CMD_READ, 32'h0, 2'd0, 32'h0, 4'd2));
      send_word(make_word(CMD_READ, 32'h0, 2'd0, 32'h0, 4'd15));
      // fill to full, lowest is the minimum score
      for (int i = 0; i < 11; i++)
         send_word(make_word(CMD_INSERT, 32'd100 + i, i[1:0], 32'h100 + i, 4'd0));
      // full table: equal to lowest is refused, one above it pushes it out
      send_word(make_word(CMD_INSERT, 32'h8000_0000, 2'd2, 32'h55, 4'd0));
      send_word(make_word(CMD_INSERT, 32'h8000_0001, 2'd2, 32'h66, 4'd0));
      send_word(make_word(CMD_READ, 32'h0, 2'd0, 32'h0, 4'd15));
      send_word(make_word(CMD_CLEAR, 32'h0, 2'd0, 32'h0, 4'd0));
      send_word(make_word(CMD_READ, 32'h0, 2'd0, 32'h0, 4'd0));

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55)
            cmd = CMD_INSERT;
         else if (pick < 97)
            cmd = CMD_READ;
         else if (pick < 99)
            cmd = CMD_CLEAR;
         else
            cmd = CMD_UNUSED;
         tag = ($urandom_range(0, 11) == 0) ? 32'h0 : $urandom;
         send_word(make_word(cmd, pick_score(), 2'($urandom_range(0, 3)), tag,
                             4'($urandom_range(0, 15))));
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (replies_left != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: top_k_score_table_core.f
sv/tks_pkg.sv
sv/tks_cell.sv
sv/tks_rsp_buffer.sv
sv/top_k_score_table_core.sv
sv/tks_checker.sv
bench/score_table_checker.sv
bench/top_k_score_table_core_test.sv
